[hdl/vdib_pkg.sv]
package vdib_pkg;
	localparam int TableDepth = 1024;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = IdxW + 1;
	localparam int FirstUnmerged = 3;
	localparam int OutIdxW = 10;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} pos_t;

	// true when two float bit patterns compare equal as floats
	function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
		logic nan_a;
		logic nan_b;
		nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (nan_a || nan_b) begin
			return 1'b0;
		end
		if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			return 1'b1;
		end
		return a == b;
	endfunction

	function automatic logic pos_eq(input pos_t a, input pos_t b);
		return feq(a.x, b.x) && feq(a.y, b.y) && feq(a.z, b.z);
	endfunction
endpackage

[hdl/vdib_if.sv]
interface vdib_in_if;
	import vdib_pkg::*;
	logic valid;
	logic ready;
	logic mesh_start;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	modport source (output valid, mesh_start, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, mesh_start, pos_x, pos_y, pos_z, output ready);
endinterface

interface vdib_out_if;
	import vdib_pkg::*;
	logic valid;
	logic ready;
	logic [OutIdxW-1:0] vertex_index;
	logic is_new;
	logic overflow;
	modport source (output valid, vertex_index, is_new, overflow, input ready);
	modport sink (input valid, vertex_index, is_new, overflow, output ready);
endinterface

[hdl/vdib_cell.sv]
module vdib_cell import vdib_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  logic shift,
	input  pos_t prev_pos,
	input  logic prev_vld,
	input  pos_t key,
	output pos_t pos,
	output logic vld,
	output logic hit
);
	pos_t pos_q;
	logic vld_q;

	// entries shift toward the tail; cell 0 takes the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clear) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			pos_q <= prev_pos;
		end
	end

	assign pos = pos_q;
	assign vld = vld_q;
	assign hit = vld_q && pos_eq(pos_q, key);
endmodule

[hdl/vdib_scan.sv]
module vdib_scan import vdib_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [TableDepth-1:0] hits,
	output logic done,
	output logic found,
	output logic [IdxW-1:0] age
);
	// registered priority search over hit vector, 32 cells a cycle, oldest first
	localparam int Seg = 32;
	localparam int NSeg = (TableDepth + Seg - 1) / Seg;
	localparam int SegW = (NSeg > 1) ? $clog2(NSeg) : 1;

	logic [TableDepth-1:0] hits_q;
	logic busy_q;
	logic [SegW-1:0] seg_q;
	logic [Seg-1:0] part;
	logic phit;
	logic [IdxW-1:0] pidx;

	always_comb begin
		part = '0;
		for (int k = 0; k < Seg; k++) begin
			if (int'(seg_q) * Seg + k < TableDepth) begin
				part[k] = hits_q[int'(seg_q) * Seg + k];
			end
		end
		phit = 1'b0;
		pidx = '0;
		// highest position is the oldest entry: highest index wins
		for (int k = 0; k < Seg; k++) begin
			if (part[k]) begin
				phit = 1'b1;
				pidx = IdxW'(int'(seg_q) * Seg + k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q <= '0;
			hits_q <= '0;
			done <= 1'b0;
			found <= 1'b0;
			age <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				seg_q <= SegW'(NSeg - 1);
				hits_q <= hits;
			end else if (busy_q) begin
				if (phit || seg_q == '0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					found <= phit;
					age <= pidx;
				end else begin
					seg_q <= seg_q - SegW'(1);
				end
			end
		end
	end
endmodule

[hdl/vertex_dedup_index_builder.sv]
// channel | dir | payload
// in_ch   | in  | mesh_start, pos_x, pos_y, pos_z
// out_ch  | out | vertex_index, is_new, overflow
// one request at a time: key compared against every cell in parallel,
// then a search of 32 cells per cycle from the oldest entry
// a match gives the result at the end of the search; a miss goes on to WRITE
// the first vertices of a mesh skip the search and go from CMP to WRITE
// arst_n empties the row at once, no clearing pass
// a waiting result holds the block; next request taken in the cycle after out_ch takes it
module vertex_dedup_index_builder import vdib_pkg::*; (
	input logic clk,
	input logic arst_n,
	vdib_in_if.sink in_ch,
	vdib_out_if.source out_ch
);
	typedef enum logic [2:0] {IDLE, CMP, SCAN, WRITE, OUT} st_t;
	st_t st_q;

	pos_t key_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0] seen_q;
	logic skip_q;
	logic clear_q;
	logic shift;
	logic scan_start;
	logic scan_done;
	logic scan_found;
	logic [IdxW-1:0] scan_age;

	pos_t cpos [TableDepth+1];
	logic cvld [TableDepth+1];
	logic [TableDepth-1:0] hits;

	// cell k holds entry cnt-1-k, newest in front
	assign cpos[0] = key_q;
	assign cvld[0] = 1'b1;

	for (genvar g = 0; g < TableDepth; g++) begin : g_cell
		vdib_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clear(clear_q), .shift(shift),
			.prev_pos(cpos[g]), .prev_vld(cvld[g]), .key(key_q),
			.pos(cpos[g+1]), .vld(cvld[g+1]), .hit(hits[g])
		);
	end

	vdib_scan u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .hits(hits),
		.done(scan_done), .found(scan_found), .age(scan_age)
	);

	assign in_ch.ready = (st_q == IDLE);
	assign shift = (st_q == WRITE) && (cnt_q < CntW'(TableDepth));
	assign scan_start = (st_q == CMP) && !skip_q;

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			key_q <= '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			cnt_q <= '0;
			seen_q <= '0;
			skip_q <= 1'b0;
			clear_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.vertex_index <= '0;
			out_ch.is_new <= 1'b0;
			out_ch.overflow <= 1'b0;
		end else begin
			clear_q <= 1'b0;
			unique case (st_q)
				IDLE: begin
					if (in_ch.valid) begin
						// mesh start raises clear_q as the key loads; the row empties in CMP, before the write
						if (in_ch.mesh_start) begin
							clear_q <= 1'b1;
							cnt_q <= '0;
							seen_q <= '0;
							skip_q <= 1'b1;
						end else begin
							skip_q <= (seen_q < 2'(FirstUnmerged));
						end
						st_q <= CMP;
					end
				end
				CMP: begin
					st_q <= skip_q ? WRITE : SCAN;
				end
				SCAN: begin
					if (scan_done) begin
						if (scan_found) begin
							out_ch.vertex_index <= OutIdxW'(cnt_q - CntW'(1) - CntW'(scan_age));
							out_ch.is_new <= 1'b0;
							out_ch.overflow <= 1'b0;
							out_ch.valid <= 1'b1;
							st_q <= OUT;
							if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
						end else begin
							st_q <= WRITE;
						end
					end
				end
				WRITE: begin
					if (cnt_q < CntW'(TableDepth)) begin
						out_ch.vertex_index <= OutIdxW'(cnt_q);
						out_ch.is_new <= 1'b1;
						out_ch.overflow <= 1'b0;
						cnt_q <= cnt_q + CntW'(1);
					end else begin
						out_ch.vertex_index <= '0;
						out_ch.is_new <= 1'b0;
						out_ch.overflow <= 1'b1;
					end
					if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
					out_ch.valid <= 1'b1;
					st_q <= OUT;
				end
				OUT: begin
					if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						st_q <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(TableDepth)) else $error("entry count past depth");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input open with result pending");
	a_new_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.is_new && out_ch.overflow)) else $error("new and overflow");
	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		shift |=> out_ch.is_new) else $error("store without new flag");
`endif
endmodule
